### src/sma_pkg.sv
// Shared types, opcodes, status codes and controller/datapath bundles for the stack ALU.
package sma_pkg;

  localparam int WORD_W  = 32;
  localparam int OP_W    = 3;
  localparam int STAT_W  = 2;
  localparam int DEPTH_W = 7;

  typedef logic [WORD_W-1:0]  word_t;
  typedef logic [OP_W-1:0]    op_t;
  typedef logic [STAT_W-1:0]  status_t;
  typedef logic [DEPTH_W-1:0] depth_t;

  localparam op_t OP_PUSH = 3'd0;
  localparam op_t OP_SUB  = 3'd1;
  localparam op_t OP_DIV  = 3'd2;
  localparam op_t OP_MUL  = 3'd3;
  localparam op_t OP_MOD  = 3'd4;
  localparam op_t OP_SWAP = 3'd5;

  localparam status_t ST_OK    = 2'd0;
  localparam status_t ST_UNDER = 2'd1;
  localparam status_t ST_DIVZ  = 2'd2;
  localparam status_t ST_FULL  = 2'd3;

  // Commands from the controller to the datapath
  typedef struct packed {
    logic    load_in;
    logic    push;
    logic    cap_sec;
    logic    exec_alu;
    logic    div_start;
    logic    div_take;
    logic    wb;
    logic    swap_lo;
    logic    swap_hi;
    logic    load_out;
    status_t status;
  } cmd_t;

  // Status from the datapath to the controller
  typedef struct packed {
    op_t  op;
    logic full;
    logic lt2;
    logic top_zero;
    logic div_done;
  } sts_t;

endpackage

### src/sma_in_if.sv
// Instruction channel: valid/ready handshake carrying opcode and push word.
interface sma_in_if;
  logic            valid;
  logic            ready;
  sma_pkg::op_t    op;
  sma_pkg::word_t  push_value;

  modport source (output valid, output op, output push_value, input ready);
  modport sink   (input valid, input op, input push_value, output ready);
endinterface

### src/sma_out_if.sv
// Result channel: valid/ready handshake carrying status, top of stack and depth.
interface sma_out_if;
  logic              valid;
  logic              ready;
  sma_pkg::status_t  status;
  sma_pkg::word_t    top_value;
  sma_pkg::depth_t   stack_depth;

  modport source (output valid, output status, output top_value, output stack_depth,
                  input ready);
  modport sink   (input valid, input status, input top_value, input stack_depth,
                  output ready);
endinterface

### src/sma_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sma_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

### src/sma_div.sv
// Radix-2 restoring signed divider: one quotient bit per cycle, truncating toward zero.
module sma_div (
  input  logic           clk,
  input  logic           rst_n,
  input  logic           start,
  input  sma_pkg::word_t a,
  input  sma_pkg::word_t b,
  output logic           done,
  output sma_pkg::word_t quo,
  output sma_pkg::word_t rem
);

  localparam int W  = sma_pkg::WORD_W;
  localparam int CNW = $clog2(W);

  logic           busy_r, busy_nxt;
  logic           done_r, done_nxt;
  logic [CNW-1:0] cnt_r, cnt_nxt;
  sma_pkg::word_t rem_r, rem_nxt;
  sma_pkg::word_t quo_r, quo_nxt;
  sma_pkg::word_t b_r, b_nxt;
  logic           neg_q_r, neg_q_nxt;
  logic           neg_r_r, neg_r_nxt;
  logic [W:0]     shifted;
  logic [W:0]     diff;

  // Trial subtract of the divisor from the shifted partial remainder
  assign shifted = {rem_r, quo_r[W-1]};
  assign diff    = shifted - {1'b0, b_r};

  always_comb begin
    busy_nxt  = busy_r;
    done_nxt  = 1'b0;
    cnt_nxt   = cnt_r;
    rem_nxt   = rem_r;
    quo_nxt   = quo_r;
    b_nxt     = b_r;
    neg_q_nxt = neg_q_r;
    neg_r_nxt = neg_r_r;
    if (start) begin
      busy_nxt  = 1'b1;
      cnt_nxt   = '0;
      rem_nxt   = '0;
      quo_nxt   = a[W-1] ? ('0 - a) : a;
      b_nxt     = b[W-1] ? ('0 - b) : b;
      neg_q_nxt = a[W-1] ^ b[W-1];
      neg_r_nxt = a[W-1];
    end else if (busy_r) begin
      if (diff[W]) begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end else begin
        rem_nxt = diff[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CNW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  // Hold control state under reset, advance the iteration otherwise
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r   <= rem_nxt;
    quo_r   <= quo_nxt;
    b_r     <= b_nxt;
    neg_q_r <= neg_q_nxt;
    neg_r_r <= neg_r_nxt;
  end

  // Apply result signs
  assign done = done_r;
  assign quo  = neg_q_r ? ('0 - quo_r) : quo_r;
  assign rem  = neg_r_r ? ('0 - rem_r) : rem_r;

endmodule

### src/sma_dp.sv
// Datapath: stack memory, cached top entry, entry counter, ALU, divider and result registers.
module sma_dp #(
  parameter int STACK_DEPTH = 64
) (
  input  logic              clk,
  input  logic              rst_n,
  input  sma_pkg::op_t      in_op,
  input  sma_pkg::word_t    in_push_value,
  input  sma_pkg::cmd_t     cmd,
  output sma_pkg::sts_t     sts,
  output sma_pkg::status_t  out_status,
  output sma_pkg::word_t    out_top_value,
  output sma_pkg::depth_t   out_stack_depth
);

  localparam int AW = $clog2(STACK_DEPTH);
  localparam int CW = $clog2(STACK_DEPTH + 1);
  localparam int DW = sma_pkg::DEPTH_W;

  sma_pkg::op_t     op_r;
  sma_pkg::word_t   val_r;
  sma_pkg::word_t   top_r, top_nxt;
  sma_pkg::word_t   sec_r;
  sma_pkg::word_t   res_r, res_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  sma_pkg::status_t ostat_r;
  sma_pkg::word_t   otop_r;
  sma_pkg::depth_t  odepth_r;

  logic [CW-1:0]    cnt_m1, cnt_m2;
  logic             ram_we;
  logic [AW-1:0]    ram_waddr;
  sma_pkg::word_t   ram_wdata;
  sma_pkg::word_t   ram_rdata;
  sma_pkg::word_t   mul_lo;
  logic             div_done;
  sma_pkg::word_t   div_quo, div_rem;

  assign cnt_m1 = count_r - CW'(1);
  assign cnt_m2 = count_r - CW'(2);
  assign mul_lo = sec_r * top_r;

  // Stack store: second entry is always read at depth minus two
  sma_ram #(.WIDTH(sma_pkg::WORD_W), .DEPTH(STACK_DEPTH)) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (cnt_m2[AW-1:0]),
    .rdata (ram_rdata)
  );

  sma_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .a     (sec_r),
    .b     (top_r),
    .done  (div_done),
    .quo   (div_quo),
    .rem   (div_rem)
  );

  // Select the memory write for push, write-back and the two swap halves
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = count_r[AW-1:0];
    ram_wdata = val_r;
    if (cmd.push) begin
      ram_we = 1'b1;
    end else if (cmd.wb) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_m2[AW-1:0];
      ram_wdata = res_r;
    end else if (cmd.swap_lo) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_m2[AW-1:0];
      ram_wdata = top_r;
    end else if (cmd.swap_hi) begin
      ram_we    = 1'b1;
      ram_waddr = cnt_m1[AW-1:0];
      ram_wdata = sec_r;
    end
  end

  // Next top, result and count
  always_comb begin
    top_nxt   = top_r;
    res_nxt   = res_r;
    count_nxt = count_r;
    if (cmd.exec_alu) begin
      res_nxt = (op_r == sma_pkg::OP_MUL) ? mul_lo : (sec_r - top_r);
    end
    if (cmd.div_take) begin
      res_nxt = (op_r == sma_pkg::OP_DIV) ? div_quo : div_rem;
    end
    if (cmd.push) begin
      top_nxt   = val_r;
      count_nxt = count_r + CW'(1);
    end
    if (cmd.wb) begin
      top_nxt   = res_r;
      count_nxt = cnt_m1;
    end
    if (cmd.swap_hi) begin
      top_nxt = sec_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else begin
      count_r <= count_nxt;
    end
    top_r <= top_nxt;
    res_r <= res_nxt;
    if (cmd.load_in) begin
      op_r  <= in_op;
      val_r <= in_push_value;
    end
    if (cmd.cap_sec) begin
      sec_r <= ram_rdata;
    end
    // Hold the finished transaction until the sink takes it
    if (cmd.load_out) begin
      ostat_r  <= cmd.status;
      otop_r   <= (count_r == '0) ? '0 : top_r;
      odepth_r <= DW'(count_r);
    end
  end

  assign sts.op       = op_r;
  assign sts.full     = (count_r == CW'(STACK_DEPTH));
  assign sts.lt2      = (count_r < CW'(2));
  assign sts.top_zero = (top_r == '0);
  assign sts.div_done = div_done;

  assign out_status      = ostat_r;
  assign out_top_value   = otop_r;
  assign out_stack_depth = odepth_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(STACK_DEPTH))
    else $error("stack count above capacity");

  a_push_inc: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.push |=> count_r == $past(count_r) + CW'(1))
    else $error("push did not grow the stack by one");

  a_wb_dec: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.wb |=> (count_r == $past(count_r) - CW'(1)) && (top_r == $past(res_r)))
    else $error("binary op write-back did not pop one entry");

endmodule

### src/sma_ctrl.sv
// Controller: sequences decode, operand read, execute, write-back and result handoff.
module sma_ctrl (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          in_valid,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  sma_pkg::sts_t sts,
  output sma_pkg::cmd_t cmd
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_EXEC = 3'd3;
  localparam logic [2:0] S_DIV  = 3'd4;
  localparam logic [2:0] S_WB   = 3'd5;
  localparam logic [2:0] S_SWAP = 3'd6;
  localparam logic [2:0] S_DONE = 3'd7;

  logic [2:0]       state_r, state_nxt;
  logic             out_valid_r, out_valid_nxt;
  sma_pkg::status_t status_r, status_nxt;
  logic             is_divmod;

  assign is_divmod = (sts.op == sma_pkg::OP_DIV) || (sts.op == sma_pkg::OP_MOD);

  // Next state and commands
  always_comb begin
    state_nxt  = state_r;
    status_nxt = status_r;
    cmd        = '0;
    cmd.status = status_r;
    in_ready   = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt   = S_DEC;
        end
      end
      S_DEC: begin
        status_nxt = sma_pkg::ST_OK;
        state_nxt  = S_DONE;
        case (sts.op)
          sma_pkg::OP_PUSH: begin
            if (sts.full) begin
              status_nxt = sma_pkg::ST_FULL;
            end else begin
              cmd.push = 1'b1;
            end
          end
          sma_pkg::OP_SUB, sma_pkg::OP_DIV, sma_pkg::OP_MUL,
          sma_pkg::OP_MOD, sma_pkg::OP_SWAP: begin
            if (sts.lt2) begin
              status_nxt = sma_pkg::ST_UNDER;
            end else if (is_divmod && sts.top_zero) begin
              status_nxt = sma_pkg::ST_DIVZ;
            end else begin
              state_nxt = S_RD;
            end
          end
          default: begin
            status_nxt = sma_pkg::ST_OK;
          end
        endcase
      end
      S_RD: begin
        cmd.cap_sec = 1'b1;
        state_nxt   = S_EXEC;
      end
      S_EXEC: begin
        case (sts.op)
          sma_pkg::OP_SUB, sma_pkg::OP_MUL: begin
            cmd.exec_alu = 1'b1;
            state_nxt    = S_WB;
          end
          sma_pkg::OP_DIV, sma_pkg::OP_MOD: begin
            cmd.div_start = 1'b1;
            state_nxt     = S_DIV;
          end
          sma_pkg::OP_SWAP: begin
            cmd.swap_lo = 1'b1;
            state_nxt   = S_SWAP;
          end
          default: begin
            state_nxt = S_DONE;
          end
        endcase
      end
      S_DIV: begin
        if (sts.div_done) begin
          cmd.div_take = 1'b1;
          state_nxt    = S_WB;
        end
      end
      S_WB: begin
        cmd.wb    = 1'b1;
        state_nxt = S_DONE;
      end
      S_SWAP: begin
        cmd.swap_hi = 1'b1;
        state_nxt   = S_DONE;
      end
      S_DONE: begin
        if (!out_valid_r || out_ready) begin
          cmd.load_out = 1'b1;
          state_nxt    = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Raise valid on load, drop it once the sink takes the transaction
  assign out_valid_nxt = cmd.load_out ? 1'b1 : (out_ready ? 1'b0 : out_valid_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
      status_r    <= sma_pkg::ST_OK;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      status_r    <= status_nxt;
    end
  end

  assign out_valid = out_valid_r;

  a_div_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
    sts.div_done |-> state_r == S_DIV)
    else $error("divider finished outside the divide wait");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load_out |-> (!out_valid_r || out_ready))
    else $error("pending result overwritten");

  a_valid_from_done: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> $past(state_r) == S_DONE)
    else $error("result raised outside completion");

endmodule

### src/stack_machine_alu_top.sv
// Top level of the stack machine ALU: controller, datapath and the two channels.
// One instruction is taken at a time. Push, unused opcodes and every rejected
// instruction (stack full, underflow, divide by zero) skip the operand read; div
// and mod wait on the radix-2 divider, which retires one quotient bit per cycle.
// Operand fetch of the second entry goes through the registered read port of the
// stack memory, while the top entry is held in a register. The result sits in an
// output register, so the next instruction is accepted while it waits to be taken.
// The stack memory needs no clearing pass: only entries below the depth are read.
module stack_machine_alu_top #(
  parameter int STACK_DEPTH = 64
) (
  input  logic       clk,
  input  logic       rst_n,
  sma_in_if.sink     in_ch,
  sma_out_if.source  out_ch
);

  sma_pkg::cmd_t cmd;
  sma_pkg::sts_t sts;

  sma_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_ch.valid),
    .in_ready  (in_ch.ready),
    .out_valid (out_ch.valid),
    .out_ready (out_ch.ready),
    .sts       (sts),
    .cmd       (cmd)
  );

  sma_dp #(.STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_op           (in_ch.op),
    .in_push_value   (in_ch.push_value),
    .cmd             (cmd),
    .sts             (sts),
    .out_status      (out_ch.status),
    .out_top_value   (out_ch.top_value),
    .out_stack_depth (out_ch.stack_depth)
  );

endmodule

### dv/tb.sv
// Self-checking testbench for the stack machine ALU: random handshakes, predicted results.
`timescale 1ns / 100ps

module tb;

  localparam int STACK_DEPTH = 64;
  localparam int RAND_ITEMS  = 450;
  localparam int IDLE_LIMIT  = 5000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_WAIT  = 60;
  localparam int PRINT_MAX   = 30;

  // Unused opcodes: the block must treat these as no-ops
  localparam sma_pkg::op_t OP_NOP6 = 3'd6;
  localparam sma_pkg::op_t OP_NOP7 = 3'd7;

  localparam sma_pkg::word_t INT_MIN = 32'h8000_0000;
  localparam sma_pkg::word_t INT_MAX = 32'h7FFF_FFFF;

  typedef struct packed {
    sma_pkg::op_t   op;
    sma_pkg::word_t value;
  } instr_t;

  typedef struct packed {
    sma_pkg::status_t status;
    sma_pkg::word_t   top;
    sma_pkg::depth_t  depth;
  } report_t;

  logic clk;
  logic rst_n;

  sma_in_if  in_ch ();
  sma_out_if out_ch ();

  stack_machine_alu_top #(.STACK_DEPTH(STACK_DEPTH)) dut (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Stimulus and expected-report storage
  instr_t  instr_q[$];
  report_t top_reports[$];

  // Shadow of the operand stack
  sma_pkg::word_t stack_mem [STACK_DEPTH];
  int             stack_cnt;

  // Approximate depth used only to shape the generated sequences
  int gen_depth;

  int  err_cnt;
  int  issued_cnt;
  int  checked_cnt;
  int  status_cnt [4];
  logic in_acc;
  int  idle_cycles;

  int  in_gap, in_calm;
  int  out_gap, out_calm;
  int  hold_left;
  logic held_once;

  // Generate clock
  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Signed truncating divide on word patterns; divisor is nonzero
  function automatic void div_words(input sma_pkg::word_t a, input sma_pkg::word_t b,
                                    output sma_pkg::word_t q, output sma_pkg::word_t r);
    logic           a_neg, b_neg;
    sma_pkg::word_t ua, ub;
    a_neg = a[sma_pkg::WORD_W-1];
    b_neg = b[sma_pkg::WORD_W-1];
    ua = a_neg ? -a : a;
    ub = b_neg ? -b : b;
    q = ua / ub;
    r = ua % ub;
    if (a_neg != b_neg) q = -q;
    if (a_neg) r = -r;
  endfunction

  // Execute one instruction on the shadow stack and return the report it yields
  function automatic report_t stack_exec(sma_pkg::op_t op, sma_pkg::word_t val);
    report_t        rep;
    sma_pkg::word_t top_w, sec_w, res, q, rm;
    logic           fold;
    rep.status = sma_pkg::ST_OK;
    fold = 1'b0;
    res = '0;
    case (op)
      sma_pkg::OP_PUSH: begin
        if (stack_cnt >= STACK_DEPTH) begin
          rep.status = sma_pkg::ST_FULL;
        end else begin
          stack_mem[stack_cnt] = val;
          stack_cnt++;
        end
      end
      sma_pkg::OP_SUB, sma_pkg::OP_DIV, sma_pkg::OP_MUL, sma_pkg::OP_MOD,
      sma_pkg::OP_SWAP: begin
        if (stack_cnt < 2) begin
          rep.status = sma_pkg::ST_UNDER;
        end else begin
          top_w = stack_mem[stack_cnt-1];
          sec_w = stack_mem[stack_cnt-2];
          if (op == sma_pkg::OP_SUB) begin
            res = sec_w - top_w;
            fold = 1'b1;
          end else if (op == sma_pkg::OP_MUL) begin
            res = sec_w * top_w;
            fold = 1'b1;
          end else if (op == sma_pkg::OP_DIV || op == sma_pkg::OP_MOD) begin
            if (top_w == '0) begin
              rep.status = sma_pkg::ST_DIVZ;
            end else begin
              div_words(sec_w, top_w, q, rm);
              res = (op == sma_pkg::OP_DIV) ? q : rm;
              fold = 1'b1;
            end
          end else begin
            stack_mem[stack_cnt-1] = sec_w;
            stack_mem[stack_cnt-2] = top_w;
          end
        end
      end
      default: ;
    endcase
    if (fold) begin
      stack_mem[stack_cnt-2] = res;
      stack_cnt--;
    end
    rep.top   = (stack_cnt > 0) ? stack_mem[stack_cnt-1] : '0;
    rep.depth = sma_pkg::depth_t'(stack_cnt);
    return rep;
  endfunction

  // Queue one instruction and track the rough depth for sequence shaping
  task automatic add_instr(sma_pkg::op_t op, sma_pkg::word_t val);
    instr_t it;
    it.op = op;
    it.value = val;
    instr_q.push_back(it);
    if (op == sma_pkg::OP_PUSH) begin
      if (gen_depth < STACK_DEPTH) gen_depth++;
    end else if (op >= sma_pkg::OP_SUB && op <= sma_pkg::OP_MOD) begin
      if (gen_depth >= 2) gen_depth--;
    end
  endtask

  // Mix of random words, small values and the extremes
  function automatic sma_pkg::word_t pick_word();
    int r, v;
    r = $urandom_range(0, 9);
    if (r < 4) return $urandom;
    if (r < 7) begin
      v = $urandom_range(0, 16);
      return sma_pkg::word_t'(v - 8);
    end
    if (r == 7) return INT_MIN;
    if (r == 8) return INT_MAX;
    v = $urandom_range(0, 2);
    return sma_pkg::word_t'(v - 1);
  endfunction

  function automatic sma_pkg::op_t pick_alu_op();
    case ($urandom_range(0, 4))
      0: return sma_pkg::OP_SUB;
      1: return sma_pkg::OP_DIV;
      2: return sma_pkg::OP_MUL;
      3: return sma_pkg::OP_MOD;
      default: return sma_pkg::OP_SWAP;
    endcase
  endfunction

  task automatic report_mismatch(string what, logic [31:0] got, logic [31:0] want);
    if (err_cnt < PRINT_MAX)
      $display("[%0t] mismatch %s: got %h want %h", $time, what, got, want);
    err_cnt++;
  endtask

  // Fill the stimulus queue: directed corner cases, then shaped random sequences
  task automatic build_stimulus();
    int n, len, burst;
    // Underflow on an empty and a one-entry stack
    add_instr(sma_pkg::OP_SUB, $urandom);
    add_instr(sma_pkg::OP_SWAP, $urandom);
    add_instr(sma_pkg::OP_PUSH, INT_MIN);
    add_instr(sma_pkg::OP_DIV, $urandom);
    // Swap twice, then the most negative word divided by minus one
    add_instr(sma_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_instr(sma_pkg::OP_SWAP, $urandom);
    add_instr(sma_pkg::OP_SWAP, $urandom);
    add_instr(sma_pkg::OP_DIV, $urandom);
    add_instr(sma_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_instr(sma_pkg::OP_MOD, $urandom);
    // Divide by zero for both div and mod
    add_instr(sma_pkg::OP_PUSH, INT_MAX);
    add_instr(sma_pkg::OP_PUSH, '0);
    add_instr(sma_pkg::OP_DIV, $urandom);
    add_instr(sma_pkg::OP_MOD, $urandom);
    add_instr(sma_pkg::OP_SUB, $urandom);
    // Multiply by minus one, then subtract down to the most negative word
    add_instr(sma_pkg::OP_PUSH, 32'hFFFF_FFFF);
    add_instr(sma_pkg::OP_MUL, $urandom);
    add_instr(sma_pkg::OP_PUSH, 32'd1);
    add_instr(sma_pkg::OP_SUB, $urandom);
    // Truncation toward zero and remainder sign
    add_instr(sma_pkg::OP_PUSH, sma_pkg::word_t'(-7));
    add_instr(sma_pkg::OP_PUSH, 32'd2);
    add_instr(sma_pkg::OP_DIV, $urandom);
    add_instr(sma_pkg::OP_PUSH, 32'd2);
    add_instr(sma_pkg::OP_MOD, $urandom);
    // Unused opcodes do nothing
    add_instr(OP_NOP6, 32'h5555_5555);
    add_instr(OP_NOP7, 32'hAAAA_AAAA);

    // Fill to the top and push past it
    n = 0;
    len = STACK_DEPTH - gen_depth + 3;
    repeat (len) begin
      add_instr(sma_pkg::OP_PUSH, pick_word());
      n++;
    end

    while (n < RAND_ITEMS) begin
      burst = $urandom_range(0, 19);
      if (burst == 0) begin
        // Deep refill that usually reaches the full stack again
        len = $urandom_range(30, 70);
        repeat (len) add_instr(sma_pkg::OP_PUSH, pick_word());
      end else if (burst < 9) begin
        len = $urandom_range(1, 8);
        repeat (len) add_instr(sma_pkg::OP_PUSH, pick_word());
      end else if (burst < 18) begin
        len = $urandom_range(1, 6);
        repeat (len) add_instr(pick_alu_op(), $urandom);
      end else begin
        // Noise: any opcode, including unused ones and underflowing ones
        len = $urandom_range(1, 4);
        repeat (len) add_instr(sma_pkg::op_t'($urandom_range(0, 7)), $urandom);
      end
      n += len;
    end
  endtask

  // Drive instruction transactions at the falling edge
  always @(negedge clk) begin : drive_instr
    instr_t nx;
    logic   go;
    int     r;
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
    end else if (!in_ch.valid || in_acc) begin
      go = 1'b0;
      if (in_gap > 0) begin
        in_gap--;
      end else if (instr_q.size() != 0) begin
        go = 1'b1;
        if (in_calm > 0) begin
          in_calm--;
        end else begin
          r = $urandom_range(0, 99);
          if (r < 3) begin
            in_calm = $urandom_range(40, 150);
          end else if (r < 35) begin
            in_gap = (r < 32) ? $urandom_range(0, 2) : $urandom_range(10, 40);
            go = 1'b0;
          end
        end
      end
      if (go) begin
        nx = instr_q.pop_front();
        in_ch.op         <= nx.op;
        in_ch.push_value <= nx.value;
      end
      in_ch.valid <= go;
    end
  end

  // Drive result-channel ready, with one long hold-off to back the block up
  always @(negedge clk) begin : drive_ready
    logic rdy;
    int   r;
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
    end else begin
      rdy = 1'b1;
      if (!held_once && issued_cnt >= 60) begin
        held_once = 1'b1;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        rdy = 1'b0;
      end else if (out_gap > 0) begin
        out_gap--;
        rdy = 1'b0;
      end else if (out_calm > 0) begin
        out_calm--;
      end else begin
        r = $urandom_range(0, 99);
        if (r < 3) begin
          out_calm = $urandom_range(40, 150);
        end else if (r < 30) begin
          out_gap = (r < 27) ? $urandom_range(0, 2) : $urandom_range(15, 60);
          rdy = 1'b0;
        end
      end
      out_ch.ready <= rdy;
    end
  end

  // Sample both channels: predict on input transactions, check output transactions
  always @(posedge clk) begin : monitor
    report_t want;
    if (!rst_n) begin
      in_acc <= 1'b0;
    end else begin
      in_acc <= in_ch.valid && in_ch.ready;
      if (out_ch.valid && out_ch.ready) begin
        if (top_reports.size() == 0) begin
          report_mismatch("unexpected result", {30'd0, out_ch.status}, '0);
        end else begin
          want = top_reports.pop_front();
          if (out_ch.status !== want.status)
            report_mismatch("status", {30'd0, out_ch.status}, {30'd0, want.status});
          if (out_ch.top_value !== want.top)
            report_mismatch("top_value", out_ch.top_value, want.top);
          if (out_ch.stack_depth !== want.depth)
            report_mismatch("stack_depth", {25'd0, out_ch.stack_depth}, {25'd0, want.depth});
          status_cnt[want.status]++;
        end
        checked_cnt++;
      end
      if (in_ch.valid && in_ch.ready) begin
        top_reports.push_back(stack_exec(in_ch.op, in_ch.push_value));
        issued_cnt++;
      end
    end
  end

  // End the run when nothing moves for too long
  always @(posedge clk) begin
    if (rst_n) begin
      if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
        idle_cycles = 0;
      else
        idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("[%0t] watchdog: no transaction for %0d cycles", $time, IDLE_LIMIT);
        $display("TEST FAILED");
        $finish;
      end
    end
  end

  initial begin
    in_ch.valid      = 1'b0;
    in_ch.op         = sma_pkg::OP_PUSH;
    in_ch.push_value = '0;
    out_ch.ready     = 1'b0;
    rst_n       = 1'b0;
    err_cnt     = 0;
    issued_cnt  = 0;
    checked_cnt = 0;
    status_cnt  = '{0, 0, 0, 0};
    idle_cycles = 0;
    in_gap   = 0;
    in_calm  = 0;
    out_gap  = 0;
    out_calm = 0;
    hold_left = 0;
    held_once = 1'b0;
    stack_cnt = 0;
    gen_depth = 0;
    build_stimulus();

    // Hold reset, then release it at a falling edge
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // Drain: all stimulus taken and every report returned
    while (instr_q.size() != 0 || in_ch.valid || top_reports.size() != 0)
      @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (top_reports.size() != 0)
      report_mismatch("missing results", top_reports.size(), '0);

    $display("Ran %0d instructions, checked %0d results against the shadow stack.",
             issued_cnt, checked_cnt);
    $display("Status mix: %0d ok, %0d underflow, %0d divide-by-zero, %0d stack-full.",
             status_cnt[sma_pkg::ST_OK], status_cnt[sma_pkg::ST_UNDER],
             status_cnt[sma_pkg::ST_DIVZ], status_cnt[sma_pkg::ST_FULL]);
    if (err_cnt == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
